FILE: hw/rtl/rpch_pkg.sv
package rpch_pkg;

  localparam int MAX_OBJECTS = 256;
  localparam int CNT_W = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int DW = 32;
  localparam int HOBJ_W = 8;
  localparam int IN_DW = 8 * DW;
  localparam int OUT_DW = 6 * DW + HOBJ_W;
  localparam int STEP_W = 7;

  typedef enum logic [5:0] {
    OP_NOP, OP_LOAD_RAY, OP_LOAD_OBJ, OP_EMIT, OP_CLR_OC, OP_CLR_ACC,
    OP_MUL_DV, OP_MUL_VV, OP_MUL_DA, OP_MUL_OA, OP_MUL_RR, OP_MUL_BB, OP_MUL_DT,
    OP_ACC_F, OP_ACC_U, OP_SET_B, OP_SET_C, OP_SUB_RR, OP_SET_DISC,
    OP_SQRT_DISC, OP_GET_S, OP_ROOTS, OP_SET_DEN, OP_SET_NUM, OP_DIV_T, OP_GET_T,
    OP_SET_P, OP_REL, OP_SQRT_LEN, OP_GET_LEN, OP_DIV_N, OP_GET_N, OP_DSUB,
    OP_UPDATE
  } dp_op_t;

  typedef enum logic [2:0] {
    C_NEXT, C_WAIT, C_MISS, C_GOTO, C_DONE
  } uc_ctl_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    dp_cmd_t cmd;
    uc_ctl_t ctl;
  } uc_word_t;

  typedef struct packed {
    logic ok;
    logic skip;
    logic unit_done;
  } dp_stat_t;

  localparam logic [STEP_W-1:0] SPH_START = 7'd0;
  localparam logic [STEP_W-1:0] PLN_START = 7'd25;
  localparam logic [STEP_W-1:0] PT_START  = 7'd44;

  function automatic uc_word_t mk(input dp_op_t op, input logic [1:0] idx,
                                  input uc_ctl_t ctl);
    uc_word_t w;
    w.cmd.op  = op;
    w.cmd.idx = idx;
    w.ctl     = ctl;
    return w;
  endfunction

  // Microprogram: sphere from SPH_START, plane from PLN_START, both join at PT_START.
  function automatic uc_word_t uc_rom(input logic [STEP_W-1:0] step);
    uc_word_t w;
    case (step)
      7'd0:  w = mk(OP_CLR_OC,    2'd0, C_NEXT);
      7'd1:  w = mk(OP_MUL_DV,    2'd0, C_NEXT);
      7'd2:  w = mk(OP_ACC_F,     2'd0, C_NEXT);
      7'd3:  w = mk(OP_MUL_DV,    2'd1, C_NEXT);
      7'd4:  w = mk(OP_ACC_F,     2'd0, C_NEXT);
      7'd5:  w = mk(OP_MUL_DV,    2'd2, C_NEXT);
      7'd6:  w = mk(OP_ACC_F,     2'd0, C_NEXT);
      7'd7:  w = mk(OP_SET_B,     2'd0, C_NEXT);
      7'd8:  w = mk(OP_MUL_VV,    2'd0, C_NEXT);
      7'd9:  w = mk(OP_ACC_F,     2'd0, C_NEXT);
      7'd10: w = mk(OP_MUL_VV,    2'd1, C_NEXT);
      7'd11: w = mk(OP_ACC_F,     2'd0, C_NEXT);
      7'd12: w = mk(OP_MUL_VV,    2'd2, C_NEXT);
      7'd13: w = mk(OP_ACC_F,     2'd0, C_NEXT);
      7'd14: w = mk(OP_SET_C,     2'd0, C_NEXT);
      7'd15: w = mk(OP_MUL_RR,    2'd0, C_NEXT);
      7'd16: w = mk(OP_SUB_RR,    2'd0, C_NEXT);
      7'd17: w = mk(OP_MUL_BB,    2'd0, C_NEXT);
      7'd18: w = mk(OP_SET_DISC,  2'd0, C_NEXT);
      7'd19: w = mk(OP_NOP,       2'd0, C_MISS);
      7'd20: w = mk(OP_SQRT_DISC, 2'd0, C_NEXT);
      7'd21: w = mk(OP_GET_S,     2'd0, C_WAIT);
      7'd22: w = mk(OP_ROOTS,     2'd0, C_NEXT);
      7'd23: w = mk(OP_NOP,       2'd0, C_MISS);
      7'd24: w = mk(OP_NOP,       2'd0, C_GOTO);
      7'd25: w = mk(OP_CLR_ACC,   2'd0, C_NEXT);
      7'd26: w = mk(OP_MUL_DA,    2'd0, C_NEXT);
      7'd27: w = mk(OP_ACC_F,     2'd0, C_NEXT);
      7'd28: w = mk(OP_MUL_DA,    2'd1, C_NEXT);
      7'd29: w = mk(OP_ACC_F,     2'd0, C_NEXT);
      7'd30: w = mk(OP_MUL_DA,    2'd2, C_NEXT);
      7'd31: w = mk(OP_ACC_F,     2'd0, C_NEXT);
      7'd32: w = mk(OP_SET_DEN,   2'd0, C_NEXT);
      7'd33: w = mk(OP_NOP,       2'd0, C_MISS);
      7'd34: w = mk(OP_MUL_OA,    2'd0, C_NEXT);
      7'd35: w = mk(OP_ACC_F,     2'd0, C_NEXT);
      7'd36: w = mk(OP_MUL_OA,    2'd1, C_NEXT);
      7'd37: w = mk(OP_ACC_F,     2'd0, C_NEXT);
      7'd38: w = mk(OP_MUL_OA,    2'd2, C_NEXT);
      7'd39: w = mk(OP_ACC_F,     2'd0, C_NEXT);
      7'd40: w = mk(OP_SET_NUM,   2'd0, C_NEXT);
      7'd41: w = mk(OP_DIV_T,     2'd0, C_NEXT);
      7'd42: w = mk(OP_GET_T,     2'd0, C_WAIT);
      7'd43: w = mk(OP_NOP,       2'd0, C_MISS);
      7'd44: w = mk(OP_MUL_DT,    2'd0, C_NEXT);
      7'd45: w = mk(OP_SET_P,     2'd0, C_NEXT);
      7'd46: w = mk(OP_MUL_DT,    2'd1, C_NEXT);
      7'd47: w = mk(OP_SET_P,     2'd1, C_NEXT);
      7'd48: w = mk(OP_MUL_DT,    2'd2, C_NEXT);
      7'd49: w = mk(OP_SET_P,     2'd2, C_NEXT);
      7'd50: w = mk(OP_REL,       2'd0, C_NEXT);
      7'd51: w = mk(OP_MUL_VV,    2'd0, C_NEXT);
      7'd52: w = mk(OP_ACC_U,     2'd0, C_NEXT);
      7'd53: w = mk(OP_MUL_VV,    2'd1, C_NEXT);
      7'd54: w = mk(OP_ACC_U,     2'd0, C_NEXT);
      7'd55: w = mk(OP_MUL_VV,    2'd2, C_NEXT);
      7'd56: w = mk(OP_ACC_U,     2'd0, C_NEXT);
      7'd57: w = mk(OP_SQRT_LEN,  2'd0, C_NEXT);
      7'd58: w = mk(OP_GET_LEN,   2'd0, C_WAIT);
      7'd59: w = mk(OP_DIV_N,     2'd0, C_NEXT);
      7'd60: w = mk(OP_GET_N,     2'd0, C_WAIT);
      7'd61: w = mk(OP_DIV_N,     2'd1, C_NEXT);
      7'd62: w = mk(OP_GET_N,     2'd1, C_WAIT);
      7'd63: w = mk(OP_DIV_N,     2'd2, C_NEXT);
      7'd64: w = mk(OP_GET_N,     2'd2, C_WAIT);
      7'd65: w = mk(OP_DSUB,      2'd0, C_NEXT);
      7'd66: w = mk(OP_MUL_VV,    2'd0, C_NEXT);
      7'd67: w = mk(OP_ACC_U,     2'd0, C_NEXT);
      7'd68: w = mk(OP_MUL_VV,    2'd1, C_NEXT);
      7'd69: w = mk(OP_ACC_U,     2'd0, C_NEXT);
      7'd70: w = mk(OP_MUL_VV,    2'd2, C_NEXT);
      7'd71: w = mk(OP_ACC_U,     2'd0, C_NEXT);
      7'd72: w = mk(OP_UPDATE,    2'd0, C_DONE);
      default: w = mk(OP_NOP,     2'd0, C_DONE);
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/rpch_sqrt.sv
module rpch_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);
  import rpch_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [63:0] rad_r;
  logic [35:0] rem_r;
  logic [31:0] root_r;
  logic [35:0] rem_sh;
  logic [35:0] trial;

  // One result bit per cycle, restoring method.
  assign rem_sh = {rem_r[33:0], rad_r[63:62]};
  assign trial  = {2'b00, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd31;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= {rad_r[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[30:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[30:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

FILE: hw/rtl/rpch_div.sv
module rpch_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [47:0] quot
);
  import rpch_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [47:0] q_r;
  logic [31:0] rem_r;
  logic [31:0] dvs_r;
  logic [32:0] rem_sh;

  // Restoring division, one quotient bit per cycle.
  assign rem_sh = {rem_r, q_r[47]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd47;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_r <= 32'(rem_sh - {1'b0, dvs_r});
        q_r   <= {q_r[46:0], 1'b1};
      end else begin
        rem_r <= rem_sh[31:0];
        q_r   <= {q_r[46:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

FILE: hw/rtl/rpch_dp.sv
module rpch_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rpch_pkg::dp_cmd_t        cmd,
  input  logic [rpch_pkg::IN_DW-1:0]  in_data,
  input  logic                     in_kind,
  output rpch_pkg::dp_stat_t       stat,
  output logic                     out_hit,
  output logic [rpch_pkg::OUT_DW-1:0] out_data
);
  import rpch_pkg::*;

  localparam logic signed [47:0] MAX48 = 48'sd2147483647;
  localparam logic signed [47:0] MIN48 = -48'sd2147483648;
  localparam logic signed [65:0] MAX66 = 66'sd2147483647;
  localparam logic signed [65:0] MIN66 = -66'sd2147483648;

  function automatic logic signed [31:0] sat48(input logic signed [47:0] x);
    if (x > MAX48) return 32'sh7fff_ffff;
    if (x < MIN48) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] sat66(input logic signed [65:0] x);
    if (x > MAX66) return 32'sh7fff_ffff;
    if (x < MIN66) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic logic signed [47:0] sx48(input logic signed [31:0] x);
    return {{16{x[31]}}, x};
  endfunction

  function automatic logic [31:0] mag(input logic signed [31:0] x);
    return x[31] ? 32'(-x) : x;
  endfunction

  // Signed result from a magnitude quotient, saturated to 32 bits.
  function automatic logic signed [31:0] sat_q(input logic neg, input logic [47:0] q);
    if (!neg) return (q > 48'h0000_7fff_ffff) ? 32'sh7fff_ffff : q[31:0];
    if (q >= 48'h0000_8000_0000) return 32'sh8000_0000;
    return 32'(-q[31:0]);
  endfunction

  logic signed [31:0] org_r [3];
  logic signed [31:0] dir_r [3];
  logic signed [31:0] va_r  [3];
  logic signed [31:0] v_r   [3];
  logic signed [31:0] p_r   [3];
  logic signed [31:0] n_r   [3];
  logic signed [31:0] bpos_r [3];
  logic signed [31:0] bnrm_r [3];
  logic signed [31:0] opos_r [3];
  logic signed [31:0] onrm_r [3];
  logic signed [31:0] tmin_r, tmax_r, sa_r, b_r, c_r, disc_r, t_r, den_r, num_r;
  logic [31:0]        s_r, len_r;
  logic signed [65:0] acc_r;
  logic signed [63:0] prod_r;
  logic [63:0]        bdist_r;
  logic               any_r, found_r, kind_r, ok_r, ohit_r;
  logic [CNT_W-1:0]   cnt_r, cur_r, bidx_r;
  logic [HOBJ_W-1:0]  oobj_r;

  logic [1:0]         k;
  logic signed [31:0] ma, mb;
  logic signed [47:0] sp;
  logic signed [31:0] sps, accs, tq;
  logic signed [47:0] nb, x1, x2;
  logic               in1, in2, tang;
  logic               sq_start, sq_done, dv_start, dv_done;
  logic [63:0]        sq_in;
  logic [31:0]        sq_root, dv_div;
  logic [47:0]        dv_dvd, dv_q;

  assign k    = cmd.idx;
  assign sp   = prod_r[63:16];
  assign sps  = sat48(sp);
  assign accs = sat66(acc_r);

  always_comb begin
    case (cmd.op)
      OP_MUL_DV: begin ma = dir_r[k]; mb = v_r[k];  end
      OP_MUL_VV: begin ma = v_r[k];   mb = v_r[k];  end
      OP_MUL_DA: begin ma = dir_r[k]; mb = va_r[k]; end
      OP_MUL_OA: begin ma = org_r[k]; mb = va_r[k]; end
      OP_MUL_RR: begin ma = sa_r;     mb = sa_r;    end
      OP_MUL_BB: begin ma = b_r;      mb = b_r;     end
      OP_MUL_DT: begin ma = dir_r[k]; mb = t_r;     end
      default:   begin ma = '0;       mb = '0;      end
    endcase
  end

  // Candidate roots of the quadratic; a tangent ray takes the closed interval.
  assign nb   = -sx48(b_r);
  assign x1   = (nb - $signed({16'b0, s_r})) >>> 1;
  assign x2   = (nb + $signed({16'b0, s_r})) >>> 1;
  assign tang = (disc_r == 32'sd0);
  assign in1  = tang ? (x1 >= sx48(tmin_r) && x1 <= sx48(tmax_r))
                     : (x1 > sx48(tmin_r) && x1 < sx48(tmax_r));
  assign in2  = !tang && (x2 > sx48(tmin_r) && x2 < sx48(tmax_r));
  assign tq   = sat_q(num_r[31] ^ den_r[31], dv_q);

  assign sq_start = (cmd.op == OP_SQRT_DISC) || (cmd.op == OP_SQRT_LEN);
  assign sq_in    = (cmd.op == OP_SQRT_DISC) ? {16'b0, disc_r, 16'b0} : acc_r[63:0];
  assign dv_start = (cmd.op == OP_DIV_T) || (cmd.op == OP_DIV_N);
  assign dv_dvd   = (cmd.op == OP_DIV_T) ? {mag(num_r), 16'b0} : {mag(v_r[k]), 16'b0};
  assign dv_div   = (cmd.op == OP_DIV_T) ? mag(den_r) : len_r;

  rpch_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sq_in),
    .done     (sq_done),
    .root     (sq_root)
  );

  rpch_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start),
    .dividend (dv_dvd),
    .divisor  (dv_div),
    .done     (dv_done),
    .quot     (dv_q)
  );

  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
  end

  // Ray, best hit and object counter: cleared on reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        org_r[i]  <= '0;
        dir_r[i]  <= '0;
        bpos_r[i] <= '0;
        bnrm_r[i] <= '0;
      end
      tmin_r  <= '0;
      tmax_r  <= '0;
      any_r   <= 1'b0;
      found_r <= 1'b0;
      bidx_r  <= '0;
      cnt_r   <= '0;
      ok_r    <= 1'b0;
    end else begin
      case (cmd.op)
        OP_LOAD_RAY: begin
          for (int i = 0; i < 3; i++) begin
            org_r[i]  <= in_data[i*DW +: DW];
            dir_r[i]  <= in_data[(i+3)*DW +: DW];
            bpos_r[i] <= '0;
            bnrm_r[i] <= '0;
          end
          tmin_r  <= in_data[6*DW +: DW];
          tmax_r  <= in_data[7*DW +: DW];
          any_r   <= in_kind;
          found_r <= 1'b0;
          bidx_r  <= '0;
          cnt_r   <= '0;
        end
        OP_LOAD_OBJ: begin
          if (cnt_r < CNT_W'(MAX_OBJECTS - 1)) cnt_r <= cnt_r + 1'b1;
        end
        OP_EMIT: begin
          for (int i = 0; i < 3; i++) begin
            bpos_r[i] <= '0;
            bnrm_r[i] <= '0;
          end
          found_r <= 1'b0;
          bidx_r  <= '0;
          cnt_r   <= '0;
        end
        OP_SET_DISC: ok_r <= (sat48(sx48(sps) - (sx48(c_r) <<< 2)) >= 32'sd0);
        OP_ROOTS:    ok_r <= in1 || in2;
        OP_SET_DEN:  ok_r <= (accs != 32'sd0);
        OP_GET_T: begin
          if (dv_done) ok_r <= (tq >= tmin_r) && (tq <= tmax_r);
        end
        OP_UPDATE: begin
          if (any_r) begin
            found_r <= 1'b1;
            bidx_r  <= cur_r;
          end else if (!found_r || acc_r[63:0] <= bdist_r) begin
            found_r <= 1'b1;
            bidx_r  <= cur_r;
            for (int i = 0; i < 3; i++) begin
              bpos_r[i] <= p_r[i];
              bnrm_r[i] <= n_r[i];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers of the object pipeline.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD_OBJ: begin
        for (int i = 0; i < 3; i++) va_r[i] <= in_data[i*DW +: DW];
        sa_r   <= in_data[6*DW +: DW];
        kind_r <= in_kind;
        cur_r  <= cnt_r;
      end
      OP_EMIT: begin
        ohit_r <= found_r;
        oobj_r <= HOBJ_W'(bidx_r);
        for (int i = 0; i < 3; i++) begin
          opos_r[i] <= bpos_r[i];
          onrm_r[i] <= bnrm_r[i];
        end
      end
      OP_CLR_OC: begin
        for (int i = 0; i < 3; i++) v_r[i] <= sat48(sx48(org_r[i]) - sx48(va_r[i]));
        acc_r <= '0;
      end
      OP_CLR_ACC: acc_r <= '0;
      OP_ACC_F:   acc_r <= acc_r + {{18{sp[47]}}, sp};
      OP_ACC_U:   acc_r <= acc_r + {{2{prod_r[63]}}, prod_r};
      OP_SET_B: begin
        b_r   <= sat48(sx48(accs) <<< 1);
        acc_r <= '0;
      end
      OP_SET_C:    c_r <= accs;
      OP_SUB_RR:   c_r <= sat48(sx48(c_r) - sx48(sps));
      OP_SET_DISC: disc_r <= sat48(sx48(sps) - (sx48(c_r) <<< 2));
      OP_GET_S: begin
        if (sq_done) s_r <= sq_root;
      end
      OP_ROOTS:   t_r <= in1 ? x1[31:0] : x2[31:0];
      OP_SET_DEN: begin
        den_r <= accs;
        acc_r <= '0;
      end
      OP_SET_NUM: num_r <= sat48(-(sx48(accs) + sx48(sa_r)));
      OP_GET_T: begin
        if (dv_done) t_r <= tq;
      end
      OP_SET_P: p_r[k] <= sat48(sx48(org_r[k]) + sx48(sps));
      OP_REL: begin
        for (int i = 0; i < 3; i++)
          v_r[i] <= kind_r ? va_r[i] : sat48(sx48(p_r[i]) - sx48(va_r[i]));
        acc_r <= '0;
      end
      OP_GET_LEN: begin
        if (sq_done) len_r <= sq_root;
      end
      OP_GET_N: begin
        if (dv_done) n_r[k] <= (len_r == 32'd0) ? 32'sd0 : sat_q(v_r[k][31], dv_q);
      end
      OP_DSUB: begin
        for (int i = 0; i < 3; i++) v_r[i] <= sat48(sx48(p_r[i]) - sx48(org_r[i]));
        acc_r <= '0;
      end
      OP_UPDATE: begin
        if (!any_r && (!found_r || acc_r[63:0] <= bdist_r)) bdist_r <= acc_r[63:0];
      end
      default: ;
    endcase
  end

  assign stat.ok        = ok_r;
  assign stat.skip      = any_r && found_r;
  assign stat.unit_done = sq_done || dv_done;

  assign out_hit  = ohit_r;
  assign out_data = {oobj_r, onrm_r[2], onrm_r[1], onrm_r[0],
                     opos_r[2], opos_r[1], opos_r[0]};

endmodule

FILE: hw/rtl/rpch_ctrl.sv
module rpch_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_mode,
  input  logic               in_kind,
  input  logic               in_last,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  rpch_pkg::dp_stat_t stat,
  output rpch_pkg::dp_cmd_t  cmd
);
  import rpch_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              last_r, last_nxt;
  logic              ovalid_r, ovalid_nxt;
  uc_word_t          uw;
  state_t            fin_state;

  assign uw        = uc_rom(step_r);
  assign fin_state = last_r ? ST_EMIT : ST_IDLE;

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    last_nxt   = last_r;
    ovalid_nxt = ovalid_r;
    in_tready  = 1'b0;
    cmd.op     = OP_NOP;
    cmd.idx    = 2'd0;
    if (out_tready) ovalid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          last_nxt = in_last;
          if (!in_mode) begin
            cmd.op    = OP_LOAD_RAY;
            state_nxt = in_last ? ST_EMIT : ST_IDLE;
          end else begin
            cmd.op = OP_LOAD_OBJ;
            if (stat.skip) begin
              state_nxt = in_last ? ST_EMIT : ST_IDLE;
            end else begin
              state_nxt = ST_RUN;
              step_nxt  = in_kind ? PLN_START : SPH_START;
            end
          end
        end
      end
      ST_RUN: begin
        cmd = uw.cmd;
        case (uw.ctl)
          C_NEXT: step_nxt = step_r + 1'b1;
          C_WAIT: begin
            if (stat.unit_done) step_nxt = step_r + 1'b1;
          end
          C_MISS: begin
            if (!stat.ok) state_nxt = fin_state;
            else step_nxt = step_r + 1'b1;
          end
          C_GOTO: step_nxt = PT_START;
          default: state_nxt = fin_state;
        endcase
      end
      ST_EMIT: begin
        if (!ovalid_r || out_tready) begin
          cmd.op     = OP_EMIT;
          ovalid_nxt = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      step_r   <= '0;
      last_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      step_r   <= step_nxt;
      last_r   <= last_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_tvalid = ovalid_r;

endmodule

FILE: hw/rtl/ray_primitive_closest_hit.sv
// Ray versus sphere and plane closest-hit unit in signed Q16.16. A request with
// mode 0 loads a ray (origin, unit direction, tmin, tmax, and kind 1 for any-hit).
// Requests with mode 1 then stream spheres (kind 0) or planes (kind 1). The
// request marked last yields one result: hit flag, hit position, unit normal and
// the index of the kept object. A ray marked last yields a miss at once. The
// unit takes one request at a time. A ray, and an object skipped in any-hit mode,
// only loads its registers. Any other object runs a microprogram on one shared
// 32x32 multiplier, a bit-serial square root and a bit-serial divider. The square
// root needs 32 iterations per root and the divider 48 iterations per quotient.
// A sphere hit needs two roots and three divisions and a plane hit one root and
// four divisions, and these units set most of its run time. A last request then
// loads the result register, and waits while the previous result is still held
// there. The register holds its result while the next request is taken.
module ray_primitive_closest_hit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y, vec_b_z, scalar_a, scalar_b
  input  logic [rpch_pkg::IN_DW-1:0]  in_tdata,
  // mode, kind
  input  logic [1:0]                  in_tuser,
  input  logic                        in_tlast,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // hit_pos_x, hit_pos_y, hit_pos_z, hit_norm_x, hit_norm_y, hit_norm_z, hit_object
  output logic [rpch_pkg::OUT_DW-1:0] out_tdata,
  // hit
  output logic                        out_tuser
);
  import rpch_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rpch_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_mode    (in_tuser[0]),
    .in_kind    (in_tuser[1]),
    .in_last    (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  rpch_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_tdata),
    .in_kind  (in_tuser[1]),
    .stat     (stat),
    .out_hit  (out_tuser),
    .out_data (out_tdata)
  );

endmodule

FILE: tb/ray_primitive_closest_hit_test.sv
`timescale 1ns / 100ps

module ray_primitive_closest_hit_test;
  import rpch_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int DRAIN_CYCLES = 500;
  localparam int RECV_HOLD_CYCLES = 3000;
  localparam logic MODE_RAY = 1'b0;
  localparam logic MODE_OBJ = 1'b1;
  localparam logic KIND_SPHERE = 1'b0;
  localparam logic KIND_PLANE = 1'b1;
  localparam logic KIND_CLOSEST = 1'b0;
  localparam logic KIND_ANY = 1'b1;
  localparam longint FX1 = 65536;
  localparam longint S32MAX = 64'sd2147483647;
  localparam longint S32MIN = -64'sd2147483648;

  // One result as the block reports it.
  typedef struct packed {
    logic        hit;
    logic [31:0] px, py, pz, nx, ny, nz;
    logic [7:0]  obj;
  } hit_rec_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_DW-1:0] in_tdata;
  logic [1:0] in_tuser;
  logic in_tlast;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DW-1:0] out_tdata;
  logic out_tuser;

  ray_primitive_closest_hit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Idle percentages for the sender and the receiver; while hold_on is set
  // the receiver refuses every result.
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_on = 1'b0;
  int fail_count;
  int result_count;
  int hit_count;
  longint cycle_count;
  hit_rec_t expected_hits[$];

  // Shadow copy of the block's state.
  longint org[3], dir[3], tlo, thi;
  bit any_mode, found;
  longint best_p[3], best_n[3];
  int best_idx, obj_cnt;

  function automatic longint sat(input longint v);
    if (v > S32MAX) return S32MAX;
    if (v < S32MIN) return S32MIN;
    return v;
  endfunction

  // Arithmetic shift of a signed value is floor division by a power of two.
  function automatic longint fmul(input longint a, input longint b);
    return sat((a * b) >>> 16);
  endfunction

  function automatic longint fdot(input longint a[3], input longint b[3]);
    return sat(((a[0] * b[0]) >>> 16) + ((a[1] * b[1]) >>> 16) + ((a[2] * b[2]) >>> 16));
  endfunction

  function automatic longint unsigned isqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned sqsum(input longint v[3]);
    longint unsigned s, m;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      m = (v[i] < 0) ? -v[i] : v[i];
      s += m * m;
    end
    return s;
  endfunction

  function automatic void unit_vec(input longint v[3], output longint o[3]);
    longint unsigned len;
    len = isqrt(sqsum(v));
    for (int i = 0; i < 3; i++)
      o[i] = (len == 0) ? 0 : sat((v[i] * FX1) / longint'(len));
  endfunction

  function automatic void ray_point(input longint t, output longint p[3]);
    for (int i = 0; i < 3; i++) p[i] = sat(org[i] + fmul(dir[i], t));
  endfunction

  function automatic longint unsigned origin_dist(input longint p[3]);
    longint d[3];
    for (int i = 0; i < 3; i++) d[i] = sat(p[i] - org[i]);
    return sqsum(d);
  endfunction

  function automatic bit open_in(input longint x);
    return x > tlo && x < thi;
  endfunction

  function automatic bit closed_in(input longint x);
    return x >= tlo && x <= thi;
  endfunction

  function automatic bit hit_sphere(input longint c[3], input longint r,
                                    output longint p[3], output longint n[3]);
    longint oc[3], rel[3], b, cc, disc, t, s, x1, x2;
    for (int i = 0; i < 3; i++) oc[i] = sat(org[i] - c[i]);
    b = sat(2 * fdot(dir, oc));
    cc = sat(fdot(oc, oc) - fmul(r, r));
    disc = sat(fmul(b, b) - 4 * cc);
    if (disc < 0) return 0;
    if (disc > 0) begin
      s = longint'(isqrt(longint'(disc) * FX1));
      x1 = (-b - s) >>> 1;
      x2 = (-b + s) >>> 1;
      if (open_in(x1)) t = x1;
      else if (open_in(x2)) t = x2;
      else return 0;
    end else begin
      // A tangent ray is accepted on the closed interval.
      t = (-b) >>> 1;
      if (!closed_in(t)) return 0;
    end
    ray_point(t, p);
    for (int i = 0; i < 3; i++) rel[i] = sat(p[i] - c[i]);
    unit_vec(rel, n);
    return 1;
  endfunction

  function automatic bit hit_plane(input longint nv[3], input longint offset,
                                   output longint p[3], output longint n[3]);
    longint den, num, t;
    den = fdot(dir, nv);
    if (den == 0) return 0;
    num = sat(-(fdot(org, nv) + offset));
    t = sat((num * FX1) / den);
    if (!closed_in(t)) return 0;
    ray_point(t, p);
    unit_vec(nv, n);
    return 1;
  endfunction

  function automatic void clear_best();
    found = 0;
    best_idx = 0;
    obj_cnt = 0;
    for (int i = 0; i < 3; i++) begin
      best_p[i] = 0;
      best_n[i] = 0;
    end
  endfunction

  function automatic hit_rec_t best_record();
    hit_rec_t r;
    r.hit = found;
    r.px = best_p[0][31:0];
    r.py = best_p[1][31:0];
    r.pz = best_p[2][31:0];
    r.nx = best_n[0][31:0];
    r.ny = best_n[1][31:0];
    r.nz = best_n[2][31:0];
    r.obj = best_idx[7:0];
    return r;
  endfunction

  // Advances the shadow state by one accepted request and queues the result
  // that it produces, if any.
  function automatic void predict_hit(input logic mode, input logic kind, input logic last,
                                      input logic [31:0] f[8]);
    longint va[3], vb[3], sa, p[3], n[3];
    int idx;
    bit h;
    for (int i = 0; i < 3; i++) begin
      va[i] = longint'($signed(f[i]));
      vb[i] = longint'($signed(f[3 + i]));
    end
    sa = longint'($signed(f[6]));
    if (mode == MODE_RAY) begin
      org = va;
      dir = vb;
      tlo = sa;
      thi = longint'($signed(f[7]));
      any_mode = kind;
      clear_best();
      if (last) expected_hits.push_back(best_record());
      return;
    end
    idx = obj_cnt;
    if (obj_cnt < MAX_OBJECTS - 1) obj_cnt++;
    if (!(any_mode && found)) begin
      h = (kind == KIND_PLANE) ? hit_plane(va, sa, p, n) : hit_sphere(va, sa, p, n);
      if (h) begin
        if (any_mode) begin
          found = 1;
          best_idx = idx;
        end else if (!found || origin_dist(p) <= origin_dist(best_p)) begin
          // Ties go to the later object.
          found = 1;
          best_idx = idx;
          best_p = p;
          best_n = n;
        end
      end
    end
    if (last) begin
      expected_hits.push_back(best_record());
      clear_best();
    end
  endfunction

  // Offers one request, waits for it to be taken and updates the prediction.
  // The valid line stays high after acceptance and drops only when the
  // sender idles or a test drains.
  task automatic send_request(input logic mode, input logic kind, input logic last,
                              input logic [31:0] f[8]);
    logic [IN_DW-1:0] d;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    for (int i = 0; i < 8; i++) d[32 * i +: 32] = f[i];
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tuser <= {kind, mode};
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_hit(mode, kind, last, f);
  endtask

  task automatic send_ray(input longint o[3], input longint d[3], input longint lo,
                          input longint hi, input logic kind, input logic last);
    logic [31:0] f[8];
    for (int i = 0; i < 3; i++) begin
      f[i] = o[i][31:0];
      f[3 + i] = d[i][31:0];
    end
    f[6] = lo[31:0];
    f[7] = hi[31:0];
    send_request(MODE_RAY, kind, last, f);
  endtask

  // The direction and tmax words are ignored for objects, so they carry noise.
  task automatic send_object(input longint a[3], input longint s, input logic kind,
                             input logic last);
    logic [31:0] f[8];
    for (int i = 0; i < 3; i++) begin
      f[i] = a[i][31:0];
      f[3 + i] = $urandom;
    end
    f[6] = s[31:0];
    f[7] = $urandom;
    send_request(MODE_OBJ, kind, last, f);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Receiver: stalls at random or for a held stretch, and checks every
  // result against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        hit_rec_t got, exp_rec;
        got = {out_tuser, out_tdata[31:0], out_tdata[63:32], out_tdata[95:64],
               out_tdata[127:96], out_tdata[159:128], out_tdata[191:160],
               out_tdata[199:192]};
        result_count++;
        if (expected_hits.size() == 0) begin
          $error("result with no prediction waiting");
          fail_count++;
        end else begin
          exp_rec = expected_hits.pop_front();
          if (exp_rec.hit) hit_count++;
          if (got.hit !== exp_rec.hit) begin
            $error("hit expected %0d actual %0d", exp_rec.hit, got.hit); fail_count++;
          end
          if (got.px !== exp_rec.px) begin
            $error("hit_pos_x expected %h actual %h", exp_rec.px, got.px); fail_count++;
          end
          if (got.py !== exp_rec.py) begin
            $error("hit_pos_y expected %h actual %h", exp_rec.py, got.py); fail_count++;
          end
          if (got.pz !== exp_rec.pz) begin
            $error("hit_pos_z expected %h actual %h", exp_rec.pz, got.pz); fail_count++;
          end
          if (got.nx !== exp_rec.nx) begin
            $error("hit_norm_x expected %h actual %h", exp_rec.nx, got.nx); fail_count++;
          end
          if (got.ny !== exp_rec.ny) begin
            $error("hit_norm_y expected %h actual %h", exp_rec.ny, got.ny); fail_count++;
          end
          if (got.nz !== exp_rec.nz) begin
            $error("hit_norm_z expected %h actual %h", exp_rec.nz, got.nz); fail_count++;
          end
          if (got.obj !== exp_rec.obj) begin
            $error("hit_object expected %0d actual %0d", exp_rec.obj, got.obj);
            fail_count++;
          end
        end
      end
      if (hold_on) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ray_primitive_closest_hit verification failed");
      $finish;
    end
  end

  function automatic longint rand_word();
    return longint'($signed($urandom));
  endfunction

  // Small Q16.16 value in about -range..range units.
  function automatic longint rand_small(input int range);
    return longint'($signed($urandom_range(2 * range * 65536))) - longint'(range) * FX1;
  endfunction

  // Picks one of a few unit directions, or a near-unit random one.
  function automatic void rand_dir(output longint d[3]);
    longint v[3];
    int axis;
    axis = $urandom_range(5);
    if ($urandom_range(3) == 0) begin
      for (int i = 0; i < 3; i++) v[i] = rand_small(1);
      unit_vec(v, d);
    end else begin
      for (int i = 0; i < 3; i++) d[i] = 0;
      d[axis % 3] = (axis < 3) ? FX1 : -FX1;
    end
  endfunction

  // Random ray followed by a stream of objects near it.
  task automatic random_stream(input int objects);
    longint o[3], d[3], c[3], lo, hi, r;
    logic any_flag, kind;
    for (int i = 0; i < 3; i++) o[i] = rand_small(8);
    rand_dir(d);
    lo = ($urandom_range(9) == 0) ? rand_word() : rand_small(1);
    hi = ($urandom_range(9) == 0) ? rand_word() : longint'($urandom_range(40)) * FX1;
    any_flag = $urandom_range(3) == 0;
    send_ray(o, d, lo, hi, any_flag, $urandom_range(19) == 0);
    for (int k = 0; k < objects; k++) begin
      kind = $urandom_range(1);
      if ($urandom_range(15) == 0) begin
        for (int i = 0; i < 3; i++) c[i] = rand_word();
        r = rand_word();
      end else if (kind == KIND_SPHERE) begin
        for (int i = 0; i < 3; i++) c[i] = o[i] + fmul(d[i], rand_small(20)) + rand_small(2);
        r = longint'($urandom_range(6 * 65536));
      end else begin
        rand_dir(c);
        r = rand_small(20);
      end
      send_object(c, r, kind, k == objects - 1);
    end
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Directed checks: boundaries of the interval, tangents, zero denominators,
  // ties, any-hit skipping, a ray marked last and extreme field values.
  task automatic test_directed();
    longint o[3], d[3], c[3], z[3], mx[3], mn[3];
    z = '{0, 0, 0};
    mx = '{S32MAX, S32MAX, S32MAX};
    mn = '{S32MIN, S32MIN, S32MIN};
    o = '{0, 0, 0};
    d = '{FX1, 0, 0};
    // Sphere ahead, near root taken.
    send_ray(o, d, 0, 100 * FX1, KIND_CLOSEST, 1'b0);
    c = '{10 * FX1, 0, 0};
    send_object(c, 2 * FX1, KIND_SPHERE, 1'b0);
    // A tie at equal distance goes to the later plane.
    c = '{-FX1, 0, 0};
    send_object(c, 8 * FX1, KIND_PLANE, 1'b0);
    // Plane parallel to the ray has a zero denominator.
    c = '{0, FX1, 0};
    send_object(c, FX1, KIND_PLANE, 1'b1);
    // Origin inside a sphere: the far root is used.
    send_object(z, 3 * FX1, KIND_SPHERE, 1'b1);
    // Tangent sphere with the hit on the interval's end.
    send_ray(o, d, 0, 5 * FX1, KIND_CLOSEST, 1'b0);
    c = '{5 * FX1, FX1, 0};
    send_object(c, FX1, KIND_SPHERE, 1'b1);
    // Plane hit exactly at tmin and tmax.
    send_ray(o, d, 4 * FX1, 4 * FX1, KIND_CLOSEST, 1'b0);
    c = '{FX1, 0, 0};
    send_object(c, -4 * FX1, KIND_PLANE, 1'b1);
    // tmin above tmax: nothing hits.
    send_ray(o, d, 9 * FX1, FX1, KIND_CLOSEST, 1'b0);
    c = '{4 * FX1, 0, 0};
    send_object(c, FX1, KIND_SPHERE, 1'b1);
    // Any-hit mode keeps the first hit and skips the rest.
    send_ray(o, d, 0, 100 * FX1, KIND_ANY, 1'b0);
    send_object(mx, S32MAX, KIND_SPHERE, 1'b0);
    c = '{20 * FX1, 0, 0};
    send_object(c, FX1, KIND_SPHERE, 1'b0);
    c = '{5 * FX1, 0, 0};
    send_object(c, FX1, KIND_SPHERE, 1'b1);
    // Ray marked last reports a miss at once.
    send_ray(mn, mx, S32MIN, S32MAX, KIND_ANY, 1'b1);
    // Saturating values everywhere, including a zero plane normal.
    send_ray(mx, mn, S32MIN, S32MAX, KIND_CLOSEST, 1'b0);
    send_object(mn, S32MIN, KIND_SPHERE, 1'b0);
    send_object(mx, S32MAX, KIND_PLANE, 1'b0);
    send_object(z, 0, KIND_PLANE, 1'b0);
    send_object(mn, S32MAX, KIND_PLANE, 1'b1);
    send_ray(z, mx, S32MIN, S32MAX, KIND_CLOSEST, 1'b0);
    send_object(mx, S32MIN, KIND_SPHERE, 1'b1);
    wait_drained();
  endtask

  // More objects than the counter holds share the top index.
  task automatic test_counter_limit();
    longint o[3], d[3], c[3];
    o = '{0, 0, 0};
    d = '{0, 0, FX1};
    send_ray(o, d, 0, 1000 * FX1, KIND_CLOSEST, 1'b0);
    for (int k = 0; k < MAX_OBJECTS + 4; k++) begin
      c = '{0, 0, 0};
      if (k % 3 == 0) begin
        c[2] = longint'(1000 - k) * FX1;
        send_object(c, FX1, KIND_SPHERE, k == MAX_OBJECTS + 3);
      end else begin
        send_object(c, FX1, KIND_SPHERE, k == MAX_OBJECTS + 3);
      end
    end
    wait_drained();
  endtask

  task automatic test_random_phase(input int items, input int send_pct, input int recv_pct);
    int sent;
    set_idling(send_pct, recv_pct);
    sent = 0;
    while (sent < items) begin
      int n;
      n = $urandom_range(1, 6);
      random_stream(n);
      sent += n + 1;
    end
    wait_drained();
  endtask

  // The receiver holds off while streams keep coming, so the result register
  // fills and the input has to stall. The hold is timed by its own process.
  task automatic test_backpressure();
    set_idling(0, 0);
    fork
      begin
        hold_on = 1'b1;
        repeat (RECV_HOLD_CYCLES) @(posedge clk);
        hold_on = 1'b0;
      end
    join_none
    for (int k = 0; k < 6; k++) random_stream(1);
    wait_drained();
  endtask

  task automatic ref_reset_shadow();
    for (int i = 0; i < 3; i++) begin
      org[i] = 0;
      dir[i] = 0;
    end
    tlo = 0;
    thi = 0;
    any_mode = 0;
    clear_best();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    in_tlast = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fail_count = 0;
    result_count = 0;
    hit_count = 0;
    cycle_count = 0;
    ref_reset_shadow();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_counter_limit();
    test_random_phase(400, 0, 0);
    test_random_phase(400, 85, 0);
    test_random_phase(400, 0, 85);
    test_random_phase(400, 7, 7);
    test_backpressure();
    $display("Covered directed edge cases, the object counter limit and %0d results", result_count);
    $display("(%0d hits) under several idling phases and a long receiver hold-off.", hit_count);
    if (fail_count == 0 && expected_hits.size() == 0) begin
      $display("ray_primitive_closest_hit verification clean");
    end else begin
      $display("ray_primitive_closest_hit verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/rpch_pkg.sv
hw/rtl/rpch_sqrt.sv
hw/rtl/rpch_div.sv
hw/rtl/rpch_dp.sv
hw/rtl/rpch_ctrl.sv
hw/rtl/ray_primitive_closest_hit.sv
tb/ray_primitive_closest_hit_test.sv
